>>> rtl/lfte_pkg.sv
// ----------------------------------------------------------------------------
// lfte_pkg
// Shared types and constants for the link frame transfer engine.
// ----------------------------------------------------------------------------
package lfte_pkg;

  localparam int FRAME_LAST_INDEX_DEF = 13;
  localparam int BUFFER_WORDS_DEF     = 16;
  localparam int CHANNELS_DEF         = 2;

  // Number of receive inputs on the ports
  localparam int RX_INPUTS = 2;

  localparam int WORD_W = 16;
  localparam int POS_W  = 5;

  localparam logic [WORD_W-1:0] SYNC_WORD  = 16'hFEFE;
  localparam logic [POS_W-1:0]  POS_SYNC   = 5'd31;
  localparam logic [POS_W-1:0]  POS_STOP   = 5'd15;
  localparam logic [7:0]        TIMER_MODE = 8'd8;

  localparam logic [1:0] ST_READY  = 2'b01;
  localparam logic [1:0] ST_PARENT = 2'b10;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_XFER  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_REARM = 2'd3
  } cmd_t;

  // Position step: sync slot wraps to 0, otherwise count up and park at stop.
  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] r;
    if (p == POS_SYNC) begin
      r = '0;
    end else if (p < POS_STOP) begin
      r = p + 1'b1;
    end else begin
      r = POS_STOP;
    end
    return r;
  endfunction

endpackage

>>> rtl/link_frame_transfer_engine.sv
// ----------------------------------------------------------------------------
// link_frame_transfer_engine
// Framing for a two-channel 16-bit multiplayer serial link: ping-pong send
// banks, per-channel ping-pong receive banks, sync detection and status.
// ----------------------------------------------------------------------------
// Every command (load, transfer, read, rearm) is one input transaction and
// yields one result transaction. The block takes a new transaction every
// cycle unless input ready is low; a result passes two registers on its way
// to the output: the registered read of the send or receive buffer, taken
// at the accepting edge, and the output register.
// Throughput is one transaction per cycle as long as the output
// side keeps taking results; input ready drops only while a result waits
// in the output register and another is queued behind it. Buffer contents
// are not cleared at reset: a word read before it was ever written is
// undefined. No clearing pass is needed, so the block is ready right after
// reset. link_mode is written on its own channel, which is always ready.
module link_frame_transfer_engine #(
  parameter int FRAME_LAST_INDEX = lfte_pkg::FRAME_LAST_INDEX_DEF,
  parameter int BUFFER_WORDS     = lfte_pkg::BUFFER_WORDS_DEF,
  parameter int CHANNELS         = lfte_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] rx_word_a,
  input  logic [15:0] rx_word_b,
  input  logic        parent_bit,
  input  logic [3:0]  slot_index,
  input  logic [15:0] write_data,
  input  logic        channel_select,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] tx_word,
  output logic [1:0]  status_a,
  output logic [1:0]  status_b,
  output logic        restart_timer,
  output logic [15:0] read_word
);

  localparam int ADDR_W   = $clog2(BUFFER_WORDS);
  localparam int MEM_AW   = ADDR_W + 1;
  localparam int MEM_DEPTH = 2 ** MEM_AW;
  localparam int RX_CH    = (CHANNELS < lfte_pkg::RX_INPUTS) ? CHANNELS : lfte_pkg::RX_INPUTS;
  localparam int PW       = lfte_pkg::POS_W;

  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_LAST_INDEX);
  localparam logic [PW-1:0] BUF_LIM  = PW'(BUFFER_WORDS);

  // Configuration
  logic [7:0] link_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode <= '0;
    end else if (cfg_valid && cfg_ready) begin
      link_mode <= cfg_data;
    end
  end

  // Pipeline control
  logic s1_valid;
  logic s1_move;
  logic accept;
  lfte_pkg::cmd_t cmd;

  assign cmd      = lfte_pkg::cmd_t'(command);
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Control state
  logic [PW-1:0] send_position, send_position_next;
  logic          send_bank, send_bank_next;
  logic [PW-1:0] rx_pos [RX_CH];
  logic [PW-1:0] rx_pos_next [RX_CH];
  logic          rx_bank [RX_CH];
  logic          rx_bank_next [RX_CH];
  logic [1:0]    ch_status [RX_CH];
  logic [1:0]    ch_status_next [RX_CH];
  logic          rx_we [RX_CH];
  logic [MEM_AW-1:0] rx_waddr [RX_CH];
  logic          rx_re [RX_CH];
  logic [15:0]   rx_in [RX_CH];

  logic          slot_ok;
  logic          send_we;
  logic [MEM_AW-1:0] send_waddr;
  logic          send_re;
  logic [MEM_AW-1:0] send_raddr;
  logic          tx_from_mem;
  logic [15:0]   tx_const;
  logic [1:0]    st_a, st_b;

  assign slot_ok = {1'b0, slot_index} < BUF_LIM;

  always_comb begin
    send_position_next = send_position;
    send_bank_next     = send_bank;
    send_we            = 1'b0;
    send_waddr         = {~send_bank, slot_index[ADDR_W-1:0]};
    send_re            = 1'b0;
    send_raddr         = {send_bank, send_position[ADDR_W-1:0]};
    tx_from_mem        = 1'b0;
    tx_const           = '0;
    for (int c = 0; c < RX_CH; c++) begin
      rx_pos_next[c]    = rx_pos[c];
      rx_bank_next[c]   = rx_bank[c];
      ch_status_next[c] = ch_status[c];
      rx_we[c]          = 1'b0;
      rx_waddr[c]       = {rx_bank[c], rx_pos[c][ADDR_W-1:0]};
      rx_re[c]          = 1'b0;
    end

    unique case (cmd)
      lfte_pkg::CMD_LOAD: begin
        send_we = slot_ok;
      end
      lfte_pkg::CMD_XFER: begin
        if (send_position == lfte_pkg::POS_SYNC) begin
          tx_const       = lfte_pkg::SYNC_WORD;
          send_bank_next = ~send_bank;
        end else if (send_position < BUF_LIM) begin
          send_re     = 1'b1;
          tx_from_mem = 1'b1;
        end
        send_position_next = lfte_pkg::next_pos(send_position);
        for (int c = 0; c < RX_CH; c++) begin
          if (rx_in[c] == lfte_pkg::SYNC_WORD && rx_pos[c] != lfte_pkg::POS_SYNC &&
              rx_pos[c] > LAST_POS) begin
            // resync: the next word lands at position 0
            rx_pos_next[c] = lfte_pkg::next_pos(lfte_pkg::POS_SYNC);
          end else begin
            rx_we[c] = rx_pos[c] < BUF_LIM;
            if (rx_pos[c] == LAST_POS) begin
              rx_bank_next[c]   = ~rx_bank[c];
              ch_status_next[c] = ch_status[c] | lfte_pkg::ST_READY;
            end
            rx_pos_next[c] = lfte_pkg::next_pos(rx_pos[c]);
          end
          if (parent_bit) begin
            ch_status_next[c] = ch_status_next[c] | lfte_pkg::ST_PARENT;
          end
        end
      end
      lfte_pkg::CMD_READ: begin
        for (int c = 0; c < RX_CH; c++) begin
          rx_re[c] = slot_ok && (32'(channel_select) == c);
        end
      end
      lfte_pkg::CMD_REARM: begin
        send_position_next = lfte_pkg::POS_SYNC;
        for (int c = 0; c < RX_CH; c++) begin
          ch_status_next[c] = '0;
        end
      end
      default: begin
      end
    endcase

    st_a = '0;
    st_b = '0;
    for (int c = 0; c < RX_CH; c++) begin
      if (c == 0) st_a = ch_status_next[c];
      if (c == 1) st_b = ch_status_next[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_position <= lfte_pkg::POS_STOP;
      send_bank     <= 1'b0;
      for (int c = 0; c < RX_CH; c++) begin
        rx_pos[c]    <= lfte_pkg::POS_STOP;
        rx_bank[c]   <= 1'b0;
        ch_status[c] <= '0;
      end
    end else if (accept) begin
      send_position <= send_position_next;
      send_bank     <= send_bank_next;
      for (int c = 0; c < RX_CH; c++) begin
        rx_pos[c]    <= rx_pos_next[c];
        rx_bank[c]   <= rx_bank_next[c];
        ch_status[c] <= ch_status_next[c];
      end
    end
  end

  // Send buffer: both banks in one memory, bank bit on top of the address
  logic [15:0] send_mem [MEM_DEPTH];
  logic [15:0] send_q;

  always_ff @(posedge clk) begin
    if (accept && send_we) begin
      send_mem[send_waddr] <= write_data;
    end
    if (accept && send_re) begin
      send_q <= send_mem[send_raddr];
    end
  end

  // Receive buffers: one memory per channel, both banks each
  logic [15:0] rx_q [RX_CH];

  for (genvar c = 0; c < RX_CH; c++) begin : g_rx
    logic [15:0] mem [MEM_DEPTH];

    assign rx_in[c] = (c == 0) ? rx_word_a : rx_word_b;

    always_ff @(posedge clk) begin
      if (accept && rx_we[c]) begin
        mem[rx_waddr[c]] <= rx_in[c];
      end
      if (accept && rx_re[c]) begin
        rx_q[c] <= mem[{~rx_bank[c], slot_index[ADDR_W-1:0]}];
      end
    end
  end

  // Stage 1: buffer read in flight
  logic        s1_tx_mem;
  logic [15:0] s1_tx_const;
  logic [1:0]  s1_status_a, s1_status_b;
  logic        s1_restart;
  logic        s1_rd_en;
  logic        s1_chsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_tx_mem   <= tx_from_mem;
      s1_tx_const <= tx_const;
      s1_status_a <= st_a;
      s1_status_b <= st_b;
      s1_restart  <= (cmd == lfte_pkg::CMD_XFER) && (link_mode == lfte_pkg::TIMER_MODE);
      s1_rd_en    <= (cmd == lfte_pkg::CMD_READ) && slot_ok &&
                     (32'(channel_select) < RX_CH);
      s1_chsel    <= channel_select;
    end
  end

  logic [15:0] rd_sel;

  always_comb begin
    rd_sel = '0;
    for (int c = 0; c < RX_CH; c++) begin
      if (32'(s1_chsel) == c) rd_sel = rx_q[c];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      tx_word       <= s1_tx_mem ? send_q : s1_tx_const;
      status_a      <= s1_status_a;
      status_b      <= s1_status_b;
      restart_timer <= s1_restart;
      read_word     <= s1_rd_en ? rd_sel : 16'd0;
    end
  end

endmodule

>>> rtl/lfte_checker.sv
// ----------------------------------------------------------------------------
// lfte_checker
// Port-level checks for the link frame transfer engine, bound to the top.
// ----------------------------------------------------------------------------
module lfte_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] tx_word,
  input logic [15:0] read_word,
  input logic        restart_timer
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_word) && $stable(read_word))
    else $error("result changed while stalled");

  // Input backpressure only comes from a blocked output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with output free");

  // Only a read command returns a read word; it never sends
  a_read_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_word != 16'd0 |-> tx_word == 16'd0 && !restart_timer)
    else $error("read word on a non-read transaction");

  // Timer restart only on transfers, which never return a read word
  a_restart_xfer: assert property (@(posedge clk) disable iff (rst)
    out_valid && restart_timer |-> read_word == 16'd0)
    else $error("timer restart on a non-transfer transaction");

endmodule

bind link_frame_transfer_engine lfte_checker u_lfte_checker (.*);

>>> sim/lfte_checker.sv
// ----------------------------------------------------------------------------
// lfte_tb_checker
// Watches the config, command and result channels of the link frame transfer
// engine, predicts each result from its own copy of the link state and
// compares it field by field in order.
// ----------------------------------------------------------------------------
module lfte_tb_checker (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] rx_word_a,
  input  logic [15:0] rx_word_b,
  input  logic        parent_bit,
  input  logic [3:0]  slot_index,
  input  logic [15:0] write_data,
  input  logic        channel_select,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] tx_word,
  input  logic [1:0]  status_a,
  input  logic [1:0]  status_b,
  input  logic        restart_timer,
  input  logic [15:0] read_word,

  output int          errors,
  output int          pending
);

  localparam int FRAME_END = lfte_pkg::FRAME_LAST_INDEX_DEF;
  localparam int BUF_WORDS = lfte_pkg::BUFFER_WORDS_DEF;
  localparam int NUM_CH    = lfte_pkg::CHANNELS_DEF;

  typedef struct packed {
    logic [15:0] tx;
    logic [1:0]  st_a;
    logic [1:0]  st_b;
    logic        restart;
    logic [15:0] rd;
  } link_result_t;

  link_result_t expected_q[$];

  // mirrored link state
  logic [7:0]  mode_reg;
  logic [4:0]  tx_pos;
  logic        tx_bank;
  logic [15:0] tx_mem [2][BUF_WORDS];
  logic [4:0]  rx_pos [NUM_CH];
  logic        rx_bank [NUM_CH];
  logic [15:0] rx_mem [NUM_CH][2][BUF_WORDS];
  logic [1:0]  ch_status [NUM_CH];

  function automatic logic [4:0] advance_slot(input logic [4:0] p);
    return (p == lfte_pkg::POS_SYNC) ? 5'd0 :
           ((p >= lfte_pkg::POS_STOP) ? lfte_pkg::POS_STOP : p + 5'd1);
  endfunction

  task automatic report_mismatch(input string msg);
    // quiet after the first hundred so a broken block cannot flood the log
    if (errors < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic predict_command(input lfte_pkg::cmd_t c, input logic [15:0] wa,
                                 input logic [15:0] wb,
                                 input logic parent, input logic [3:0] slot,
                                 input logic [15:0] wdata, input logic chsel);
    link_result_t r;
    logic [15:0]  w;
    logic [4:0]   p;
    r = '0;
    case (c)
      lfte_pkg::CMD_LOAD: begin
        if (slot < BUF_WORDS) tx_mem[tx_bank ^ 1'b1][slot] = wdata;
      end
      lfte_pkg::CMD_XFER: begin
        if (tx_pos == lfte_pkg::POS_SYNC) begin
          r.tx    = lfte_pkg::SYNC_WORD;
          tx_bank = tx_bank ^ 1'b1;
        end else if (tx_pos < BUF_WORDS) begin
          r.tx = tx_mem[tx_bank][tx_pos[3:0]];
        end
        tx_pos = advance_slot(tx_pos);
        for (int ch = 0; ch < NUM_CH && ch < lfte_pkg::RX_INPUTS; ch++) begin
          w = (ch == 0) ? wa : wb;
          p = rx_pos[ch];
          // sync only counts once the frame is past its last word
          if (w == lfte_pkg::SYNC_WORD && p != lfte_pkg::POS_SYNC && p > FRAME_END) begin
            p = lfte_pkg::POS_SYNC;
          end else begin
            if (p < BUF_WORDS) rx_mem[ch][rx_bank[ch]][p[3:0]] = w;
            if (p == FRAME_END) begin
              rx_bank[ch]   = rx_bank[ch] ^ 1'b1;
              ch_status[ch] = ch_status[ch] | lfte_pkg::ST_READY;
            end
          end
          if (parent) ch_status[ch] = ch_status[ch] | lfte_pkg::ST_PARENT;
          rx_pos[ch] = advance_slot(p);
        end
        r.restart = (mode_reg == lfte_pkg::TIMER_MODE);
      end
      lfte_pkg::CMD_READ: begin
        if (chsel < NUM_CH && slot < BUF_WORDS)
          r.rd = rx_mem[chsel][rx_bank[chsel] ^ 1'b1][slot];
      end
      default: begin
        tx_pos = lfte_pkg::POS_SYNC;
        for (int ch = 0; ch < NUM_CH; ch++) ch_status[ch] = 2'b00;
      end
    endcase
    r.st_a = ch_status[0];
    r.st_b = (NUM_CH > 1) ? ch_status[NUM_CH - 1] : 2'b00;
    expected_q.push_back(r);
  endtask

  task automatic check_result();
    link_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result transaction with nothing expected (tx_word %h)",
                                tx_word));
    end else begin
      want = expected_q.pop_front();
      if (tx_word !== want.tx)
        report_mismatch($sformatf("tx_word %h, expected %h", tx_word, want.tx));
      if (status_a !== want.st_a)
        report_mismatch($sformatf("status_a %b, expected %b", status_a, want.st_a));
      if (status_b !== want.st_b)
        report_mismatch($sformatf("status_b %b, expected %b", status_b, want.st_b));
      if (restart_timer !== want.restart)
        report_mismatch($sformatf("restart_timer %b, expected %b", restart_timer,
                                  want.restart));
      if (read_word !== want.rd)
        report_mismatch($sformatf("read_word %h, expected %h", read_word, want.rd));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_reg = 8'd0;
      tx_pos   = lfte_pkg::POS_STOP;
      tx_bank  = 1'b0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        rx_pos[ch]    = lfte_pkg::POS_STOP;
        rx_bank[ch]   = 1'b0;
        ch_status[ch] = 2'b00;
      end
      expected_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) mode_reg = cfg_data;
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready)
        predict_command(lfte_pkg::cmd_t'(command), rx_word_a, rx_word_b, parent_bit,
                        slot_index, write_data, channel_select);
      pending = expected_q.size();
    end
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for link_frame_transfer_engine: fills both send banks and both
// receive banks of each channel, runs directed frame cases, then random
// frames and noise under varying idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES = 300;

  typedef struct {
    lfte_pkg::cmd_t cmd;
    logic [15:0] wa;
    logic [15:0] wb;
    logic        parent;
    logic [3:0]  slot;
    logic [15:0] wdata;
    logic        chsel;
  } link_req_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [15:0] rx_word_a;
  logic [15:0] rx_word_b;
  logic        parent_bit;
  logic [3:0]  slot_index;
  logic [15:0] write_data;
  logic        channel_select;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] tx_word;
  logic [1:0]  status_a;
  logic [1:0]  status_b;
  logic        restart_timer;
  logic [15:0] read_word;

  int errors;
  int pending;
  int send_idle = 0;
  int rcv_idle  = 0;
  bit hold_req  = 1'b0;

  link_frame_transfer_engine i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .rx_word_a      (rx_word_a),
    .rx_word_b      (rx_word_b),
    .parent_bit     (parent_bit),
    .slot_index     (slot_index),
    .write_data     (write_data),
    .channel_select (channel_select),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tx_word        (tx_word),
    .status_a       (status_a),
    .status_b       (status_b),
    .restart_timer  (restart_timer),
    .read_word      (read_word)
  );

  lfte_tb_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .rx_word_a      (rx_word_a),
    .rx_word_b      (rx_word_b),
    .parent_bit     (parent_bit),
    .slot_index     (slot_index),
    .write_data     (write_data),
    .channel_select (channel_select),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tx_word        (tx_word),
    .status_a       (status_a),
    .status_b       (status_b),
    .restart_timer  (restart_timer),
    .read_word      (read_word),
    .errors         (errors),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // random halfword that is never the sync word
  function automatic logic [15:0] data_word();
    logic [15:0] w;
    w = 16'($urandom_range(16'hFFFF));
    if (w == lfte_pkg::SYNC_WORD) w = 16'h0000;
    return w;
  endfunction

  function automatic logic [15:0] line_word();
    int k;
    k = $urandom_range(19);
    if (k == 0) return lfte_pkg::SYNC_WORD;
    if (k == 1) return 16'h0000;
    if (k == 2) return 16'hFFFF;
    return data_word();
  endfunction

  function automatic link_req_t any_req(input lfte_pkg::cmd_t c);
    link_req_t r;
    r.cmd    = c;
    r.wa     = 16'($urandom_range(16'hFFFF));
    r.wb     = 16'($urandom_range(16'hFFFF));
    r.parent = 1'($urandom_range(1));
    r.slot   = 4'($urandom_range(15));
    r.wdata  = 16'($urandom_range(16'hFFFF));
    r.chsel  = 1'($urandom_range(1));
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_req(input link_req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    command        <= r.cmd;
    rx_word_a      <= r.wa;
    rx_word_b      <= r.wb;
    parent_bit     <= r.parent;
    slot_index     <= r.slot;
    write_data     <= r.wdata;
    channel_select <= r.chsel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_xfer(input logic [15:0] wa, input logic [15:0] wb, input logic parent);
    link_req_t r;
    r        = any_req(lfte_pkg::CMD_XFER);
    r.wa     = wa;
    r.wb     = wb;
    r.parent = parent;
    push_req(r);
  endtask

  task automatic push_op(input lfte_pkg::cmd_t c, input logic [3:0] slot,
                         input logic [15:0] value, input logic chsel);
    link_req_t r;
    r       = any_req(c);
    r.slot  = slot;
    r.wdata = value;
    r.chsel = chsel;
    push_req(r);
  endtask

  // mode writes only once the engine has drained
  task automatic write_mode(input logic [7:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly framed bursts (sync, then frame words with loads and reads mixed in),
  // the rest free-form noise on every field
  task automatic run_random(input int n_items);
    int   sent;
    int   len;
    int   lag;
    logic parent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 7) begin
        parent = ($urandom_range(3) == 0);
        if ($urandom_range(2) == 0) begin
          push_req(any_req(lfte_pkg::CMD_REARM));
          sent++;
        end
        lag = $urandom_range(3);
        len = 17 + lag + $urandom_range(3);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(4) == 0) begin
            push_req(any_req($urandom_range(1) ? lfte_pkg::CMD_READ : lfte_pkg::CMD_LOAD));
            sent++;
          end
          push_xfer((i == 0) ? lfte_pkg::SYNC_WORD : line_word(),
                    (i == lag) ? lfte_pkg::SYNC_WORD : line_word(), parent);
          sent++;
        end
      end else begin
        repeat (6) begin
          push_req(any_req(lfte_pkg::cmd_t'($urandom_range(3))));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int drain;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_data       = 8'd0;
    in_valid       = 1'b0;
    command        = lfte_pkg::CMD_LOAD;
    rx_word_a      = 16'h0000;
    rx_word_b      = 16'h0000;
    parent_bit     = 1'b0;
    slot_index     = 4'd0;
    write_data     = 16'h0000;
    channel_select = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_mode(8'd0);

    // fill both send banks; the first transfer only after the back bank is full
    for (int i = 0; i < 16; i++) push_op(lfte_pkg::CMD_LOAD, 4'(i), data_word(), 1'b0);
    push_op(lfte_pkg::CMD_REARM, 4'd0, 16'h0000, 1'b0);
    push_xfer(data_word(), data_word(), 1'b0);
    for (int i = 0; i < 16; i++) push_op(lfte_pkg::CMD_LOAD, 4'(i), data_word(), 1'b1);
    // two full frames write every word of both receive banks on both channels
    repeat (2) begin
      push_xfer(lfte_pkg::SYNC_WORD, lfte_pkg::SYNC_WORD, 1'b0);
      repeat (17) push_xfer(data_word(), data_word(), 1'b0);
    end

    write_mode(lfte_pkg::TIMER_MODE);
    push_op(lfte_pkg::CMD_LOAD, 4'd0, 16'h0000, 1'b0);
    push_op(lfte_pkg::CMD_LOAD, 4'd15, 16'hFFFF, 1'b1);
    push_op(lfte_pkg::CMD_READ, 4'd0, 16'hFFFF, 1'b0);
    push_op(lfte_pkg::CMD_READ, 4'd15, 16'h0000, 1'b1);
    push_op(lfte_pkg::CMD_REARM, 4'd15, 16'hFFFF, 1'b1);
    // sync goes out, both channels resync
    push_xfer(lfte_pkg::SYNC_WORD, lfte_pkg::SYNC_WORD, 1'b1);
    push_xfer(16'h0000, 16'hFFFF, 1'b0);
    // sync inside a frame is plain data
    push_xfer(lfte_pkg::SYNC_WORD, 16'hFFFF, 1'b0);
    for (int i = 1; i <= 13; i++) push_xfer(data_word(), data_word(), 1'(i));
    // a resyncs past frame end, b stores
    push_xfer(lfte_pkg::SYNC_WORD, 16'hFEFF, 1'b0);
    push_op(lfte_pkg::CMD_READ, 4'd0, 16'h0000, 1'b0);
    push_op(lfte_pkg::CMD_READ, 4'd13, 16'h0000, 1'b1);

    write_mode(8'hFF);
    send_idle = 23;
    rcv_idle  = 69;
    run_random(580);

    write_mode(lfte_pkg::TIMER_MODE);
    send_idle = 69;
    rcv_idle  = 23;
    run_random(580);

    write_mode(8'd7);
    send_idle = 0;
    rcv_idle  = 0;
    hold_req  = 1'b1;
    run_random(590);

    in_valid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
